[rtl/core/glsw_pkg.sv]
// ----------------------------------------------------------------------------
// glsw_pkg
// Shared types and constants of the grid line-of-sight walker.
// ----------------------------------------------------------------------------
package glsw_pkg;

  localparam int unsigned MAP_SIZE_DEF = 32;

  localparam int unsigned CW     = 5;
  localparam int unsigned RW     = 6;
  localparam int unsigned MAP_AW = 2 * CW;
  localparam int unsigned EW     = 13;

  localparam int unsigned IN_DW  = 32;
  localparam int unsigned OUT_DW = 16;
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  localparam logic [RW-1:0] MAP_WIDTH_RST  = 6'd32;
  localparam logic [RW-1:0] MAP_HEIGHT_RST = 6'd22;

  localparam logic REG_MAP_WIDTH  = 1'b0;
  localparam logic REG_MAP_HEIGHT = 1'b1;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SQUARE,
    ST_RANGE,
    ST_WALK,
    ST_FINISH
  } glsw_state_e;

  typedef struct packed {
    logic clr;
    logic map_wr;
    logic load;
    logic square;
    logic range;
    logic step;
    logic res_load;
  } glsw_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic oor;
    logic walk_end;
    logic step_oob;
    logic out_free;
  } glsw_sts_t;

endpackage

[rtl/core/glsw_ram.sv]
// ----------------------------------------------------------------------------
// glsw_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module glsw_ram #(
  parameter int unsigned W = 1,
  parameter int unsigned D = 1024
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic                 re_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/glsw_ctrl.sv]
// ----------------------------------------------------------------------------
// glsw_ctrl
// Controller: sequences map clearing, cell writes, query setup and the walk.
// ----------------------------------------------------------------------------
module glsw_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_tvalid_i,
  input  logic               s_kind_i,
  output logic               s_tready_o,
  input  glsw_pkg::glsw_sts_t sts_i,
  output glsw_pkg::glsw_cmd_t cmd_o
);

  glsw_pkg::glsw_state_e state_q, state_d;
  logic                  accept;

  assign accept = (state_q == glsw_pkg::ST_IDLE) && s_tvalid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= glsw_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      glsw_pkg::ST_CLEAR: begin
        if (sts_i.clr_last) state_d = glsw_pkg::ST_IDLE;
      end
      glsw_pkg::ST_IDLE: begin
        if (accept && s_kind_i == glsw_pkg::KIND_QUERY) state_d = glsw_pkg::ST_SQUARE;
      end
      glsw_pkg::ST_SQUARE: begin
        state_d = glsw_pkg::ST_RANGE;
      end
      glsw_pkg::ST_RANGE: begin
        state_d = sts_i.oor ? glsw_pkg::ST_FINISH : glsw_pkg::ST_WALK;
      end
      glsw_pkg::ST_WALK: begin
        if (sts_i.walk_end || sts_i.step_oob) state_d = glsw_pkg::ST_FINISH;
      end
      glsw_pkg::ST_FINISH: begin
        if (sts_i.out_free) state_d = glsw_pkg::ST_IDLE;
      end
      default: state_d = glsw_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    s_tready_o = 1'b0;
    unique case (state_q)
      glsw_pkg::ST_CLEAR: begin
        cmd_o.clr = 1'b1;
      end
      glsw_pkg::ST_IDLE: begin
        s_tready_o   = 1'b1;
        cmd_o.map_wr = accept && (s_kind_i == glsw_pkg::KIND_WRITE);
        cmd_o.load   = accept && (s_kind_i == glsw_pkg::KIND_QUERY);
      end
      glsw_pkg::ST_SQUARE: begin
        cmd_o.square = 1'b1;
      end
      glsw_pkg::ST_RANGE: begin
        cmd_o.range = 1'b1;
      end
      glsw_pkg::ST_WALK: begin
        cmd_o.step = !sts_i.walk_end;
      end
      glsw_pkg::ST_FINISH: begin
        cmd_o.res_load = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_res_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_load |-> sts_i.out_free)
    else $error("Result loaded while the output slot is occupied.");

  a_step_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.step && !sts_i.step_oob) |=> (state_q == glsw_pkg::ST_WALK))
    else $error("Walk left after an in-bounds step.");
`endif

endmodule

[rtl/core/glsw_dp.sv]
// ----------------------------------------------------------------------------
// glsw_dp
// Datapath: blocking map, query setup arithmetic, walk stepper, result slot.
// ----------------------------------------------------------------------------
module glsw_dp #(
  parameter int unsigned MAP_SIZE = glsw_pkg::MAP_SIZE_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  glsw_pkg::glsw_cmd_t           cmd_i,
  output glsw_pkg::glsw_sts_t           sts_o,
  input  logic [glsw_pkg::IN_DW-1:0]    s_tdata_i,
  input  logic [glsw_pkg::RW-1:0]       map_width_i,
  input  logic [glsw_pkg::RW-1:0]       map_height_i,
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  output logic [glsw_pkg::OUT_DW-1:0]   m_tdata_o
);

  localparam int unsigned CW    = glsw_pkg::CW;
  localparam int unsigned RW    = glsw_pkg::RW;
  localparam int unsigned EW    = glsw_pkg::EW;
  localparam int unsigned AW    = glsw_pkg::MAP_AW;
  localparam int unsigned SW    = $clog2(2 * MAP_SIZE + 1);
  localparam logic [SW-1:0] LIMIT = SW'(2 * MAP_SIZE);

  function automatic logic near_line(input logic signed [EW-1:0] e,
                                     input logic [10:0] d2);
    logic [EW-1:0] a;
    logic [9:0]    sq;
    logic          small_e;
    a       = e[EW-1] ? EW'(-e) : EW'(e);
    small_e = (a < EW'(32));
    sq      = 10'(a[4:0]) * 10'(a[4:0]);
    return small_e && ({sq, 2'b00} < {1'b0, d2});
  endfunction

  // Input fields.
  logic [CW-1:0] in_ax, in_ay, in_bx, in_by;
  logic [RW-1:0] in_range;
  logic          in_block;

  assign in_ax    = s_tdata_i[4:0];
  assign in_ay    = s_tdata_i[9:5];
  assign in_bx    = s_tdata_i[14:10];
  assign in_by    = s_tdata_i[19:15];
  assign in_range = s_tdata_i[25:20];
  assign in_block = s_tdata_i[26];

  // Query registers.
  logic [CW-1:0]        bx_q, by_q, adx_q, ady_q;
  logic [RW-1:0]        range_q;
  logic signed [RW-1:0] dx_q, dy_q;
  logic                 sx_q, sy_q;
  logic [9:0]           dx2_q, dy2_q;
  logic [11:0]          r2_q;
  logic [10:0]          d2_q;
  logic                 oor_q;
  logic [RW-1:0]        x_q, y_q;
  logic signed [EW-1:0] e_q;
  logic [SW-1:0]        steps_q;
  logic                 chk_q;
  logic [AW-1:0]        clr_cnt_q;

  // Result slot.
  logic                 out_valid_q;
  logic                 vis_q, ooro_q;
  logic [CW-1:0]        sxo_q, syo_q;

  // Map.
  logic          ram_we, ram_wdata, ram_rdata;
  logic [AW-1:0] ram_waddr, ram_raddr;

  // Setup arithmetic.
  logic [10:0] d2_c;
  logic        oor_c;

  assign d2_c  = 11'(dx2_q) + 11'(dy2_q);
  assign oor_c = (range_q != '0) && ({1'b0, d2_c} > r2_q);

  // Step arithmetic.
  logic signed [EW-1:0] dx_e, dy_e, dyx, dxy, e1, e2, e_n;
  logic                 mv_x, mv_y;
  logic [RW-1:0]        dxs, dys, nx, ny;
  logic                 oob, at_target, walk_end;

  assign dx_e = {{(EW-RW){dx_q[RW-1]}}, dx_q};
  assign dy_e = {{(EW-RW){dy_q[RW-1]}}, dy_q};
  assign dyx  = sx_q ? dy_e : -dy_e;
  assign dxy  = sy_q ? dx_e : -dx_e;
  assign e1   = e_q + dyx;
  assign e2   = e_q - dxy;
  assign mv_x = near_line(e1, d2_q);
  assign mv_y = !mv_x && near_line(e2, d2_q);
  assign dxs  = sx_q ? RW'(1) : '1;
  assign dys  = sy_q ? RW'(1) : '1;

  always_comb begin
    nx  = x_q + dxs;
    ny  = y_q + dys;
    e_n = e1 - dxy;
    if (mv_x) begin
      ny  = y_q;
      e_n = e1;
    end else if (mv_y) begin
      nx  = x_q;
      e_n = e2;
    end
  end

  assign oob = nx[RW-1] || (nx >= map_width_i) || ny[RW-1] || (ny >= map_height_i);
  assign at_target = (x_q == {1'b0, bx_q}) && (y_q == {1'b0, by_q});
  assign walk_end  = (chk_q && ram_rdata) || at_target || (steps_q == LIMIT);

  assign ram_we    = cmd_i.clr || cmd_i.map_wr;
  assign ram_waddr = cmd_i.clr ? clr_cnt_q : {in_ay, in_ax};
  assign ram_wdata = cmd_i.clr ? 1'b0 : in_block;
  assign ram_raddr = {ny[CW-1:0], nx[CW-1:0]};

  glsw_ram #(
    .W (1),
    .D (1 << AW)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.step),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      steps_q     <= '0;
      chk_q       <= 1'b0;
    end else begin
      if (cmd_i.clr) clr_cnt_q <= clr_cnt_q + AW'(1);
      if (cmd_i.res_load) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.load) begin
        steps_q <= '0;
        chk_q   <= 1'b0;
      end else if (cmd_i.step) begin
        steps_q <= steps_q + SW'(1);
        chk_q   <= !oob;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      bx_q    <= in_bx;
      by_q    <= in_by;
      range_q <= in_range;
      dx_q    <= RW'({1'b0, in_bx}) - RW'({1'b0, in_ax});
      dy_q    <= RW'({1'b0, in_by}) - RW'({1'b0, in_ay});
      adx_q   <= (in_bx >= in_ax) ? (in_bx - in_ax) : (in_ax - in_bx);
      ady_q   <= (in_by >= in_ay) ? (in_by - in_ay) : (in_ay - in_by);
      sx_q    <= (in_ax < in_bx);
      sy_q    <= (in_ay < in_by);
      x_q     <= {1'b0, in_ax};
      y_q     <= {1'b0, in_ay};
      e_q     <= '0;
    end else if (cmd_i.step) begin
      x_q <= nx;
      y_q <= ny;
      e_q <= e_n;
    end
    if (cmd_i.load) begin
      oor_q <= 1'b0;
    end else if (cmd_i.range) begin
      oor_q <= oor_c;
    end
    if (cmd_i.square) begin
      dx2_q <= 10'(adx_q) * 10'(adx_q);
      dy2_q <= 10'(ady_q) * 10'(ady_q);
      r2_q  <= 12'(range_q) * 12'(range_q);
    end
    if (cmd_i.range) d2_q <= d2_c;
    if (cmd_i.res_load) begin
      vis_q  <= at_target && !oor_q;
      sxo_q  <= x_q[CW-1:0];
      syo_q  <= y_q[CW-1:0];
      ooro_q <= oor_q;
    end
  end

  assign sts_o.clr_last = (clr_cnt_q == '1);
  assign sts_o.oor      = oor_c;
  assign sts_o.walk_end = walk_end;
  assign sts_o.step_oob = oob;
  assign sts_o.out_free = !out_valid_q || m_tready_i;

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {4'b0000, ooro_q, syo_q, sxo_q, vis_q};

`ifndef NO_ASSERTIONS
  a_step_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    steps_q <= LIMIT)
    else $error("Step count ran past the step limit.");

  a_checked_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk_q |-> (!x_q[RW-1] && !y_q[RW-1]))
    else $error("Map lookup pending for a cell outside the grid.");

  a_result_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(vis_q && ooro_q))
    else $error("Result marked both visible and out of range.");
`endif

endmodule

[rtl/core/grid_line_of_sight_walker.sv]
// ----------------------------------------------------------------------------
// grid_line_of_sight_walker
// Line-of-sight test over a 32 x 32 map of cells that block sight.
//
//   Channel   Direction  Handshake               Payload
//   s_axis    in         tvalid/tready           tuser kind, tdata write/query
//   m_axis    out        tvalid/tready           tdata query result
//   apb       in         psel/penable/pready     map_width, map_height
//
// After reset a clearing pass sets every map cell open.
// A query makes one map read per step through the map read port and walks
// at most 2*MAP_SIZE steps.
// A finished result waits in the output register, and a new transfer is
// taken while it waits; a second result is held until the register frees.
// ----------------------------------------------------------------------------
module grid_line_of_sight_walker #(
  parameter int unsigned MAP_SIZE = glsw_pkg::MAP_SIZE_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // Fields from bit 0: start_x[5], start_y[5], end_x[5], end_y[5],
  // max_range[6], blocks_sight[1], zero fill.
  input  logic [glsw_pkg::IN_DW-1:0]    s_axis_tdata,
  // Fields from bit 0: kind[1].
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // Fields from bit 0: visible[1], stop_x[5], stop_y[5], out_of_range[1],
  // zero fill.
  output logic [glsw_pkg::OUT_DW-1:0]   m_axis_tdata,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [glsw_pkg::APB_AW-1:0]   paddr,
  input  logic [glsw_pkg::APB_DW-1:0]   pwdata,
  output logic [glsw_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  logic [glsw_pkg::RW-1:0] map_width_q, map_height_q;
  logic                    cfg_wr;
  glsw_pkg::glsw_cmd_t     cmd;
  glsw_pkg::glsw_sts_t     sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q  <= glsw_pkg::MAP_WIDTH_RST;
      map_height_q <= glsw_pkg::MAP_HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        glsw_pkg::REG_MAP_WIDTH:  map_width_q  <= pwdata[glsw_pkg::RW-1:0];
        glsw_pkg::REG_MAP_HEIGHT: map_height_q <= pwdata[glsw_pkg::RW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      glsw_pkg::REG_MAP_WIDTH:  prdata[glsw_pkg::RW-1:0] = map_width_q;
      glsw_pkg::REG_MAP_HEIGHT: prdata[glsw_pkg::RW-1:0] = map_height_q;
      default:                  prdata = '0;
    endcase
  end

  glsw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_kind_i   (s_axis_tuser),
    .s_tready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  glsw_dp #(
    .MAP_SIZE (MAP_SIZE)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .s_tdata_i    (s_axis_tdata),
    .map_width_i  (map_width_q),
    .map_height_i (map_height_q),
    .m_tvalid_o   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_o    (m_axis_tdata)
  );

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the grid line-of-sight walker. A short directed
// sequence exercises field extremes, range rejection, same start and end,
// blocking targets, obstacles and map edges. Random map writes and sight
// queries then run under several map_width and map_height settings. A
// built-in walk predictor computes each expected query result, and the
// scoreboard checks every output transfer against it, field by field.
// ----------------------------------------------------------------------------
import glsw_pkg::*;

typedef struct packed {
  logic       kind;
  logic [4:0] start_x;
  logic [4:0] start_y;
  logic [4:0] end_x;
  logic [4:0] end_y;
  logic [5:0] max_range;
  logic       blocks_sight;
} sight_req_t;

typedef struct packed {
  logic       visible;
  logic [4:0] stop_x;
  logic [4:0] stop_y;
  logic       out_of_range;
} sight_res_t;

class sight_scoreboard;
  bit         wall_map [1024];
  int         width_cfg  = int'(MAP_WIDTH_RST);
  int         height_cfg = int'(MAP_HEIGHT_RST);
  sight_res_t expected_sight [$];
  int         errors = 0;

  function void set_reg(logic reg_sel, int value);
    if (reg_sel == REG_MAP_WIDTH) begin
      width_cfg = value & 63;
    end else begin
      height_cfg = value & 63;
    end
  endfunction

  function bit cell_open(int x, int y);
    if (x < 0 || y < 0 || x >= 32 || y >= 32) return 1'b0;
    if (x >= width_cfg || y >= height_cfg) return 1'b0;
    return !wall_map[y * 32 + x];
  endfunction

  function sight_res_t trace_sight(sight_req_t r);
    sight_res_t res;
    longint     dx, dy, d2, e1, e2, lim;
    int         ax, ay, bx, by, x, y, stx, sty, steps;
    bit         halted;
    ax = r.start_x;
    ay = r.start_y;
    bx = r.end_x;
    by = r.end_y;
    dx = bx - ax;
    dy = by - ay;
    d2 = dx * dx + dy * dy;
    lim = r.max_range;
    res = '0;
    if (lim != 0 && d2 > lim * lim) begin
      res.stop_x = r.start_x;
      res.stop_y = r.start_y;
      res.out_of_range = 1'b1;
      return res;
    end
    stx = (ax < bx) ? 1 : -1;
    sty = (ay < by) ? 1 : -1;
    x = ax;
    y = ay;
    steps = 0;
    halted = 1'b0;
    while (!halted && (x != bx || y != by) && steps < 2 * int'(MAP_SIZE_DEF)) begin
      e1 = dy * (x - ax + stx) - dx * (y - ay);
      e2 = dy * (x - ax) - dx * (y - ay + sty);
      if (4 * e1 * e1 < d2) begin
        x += stx;
      end else if (4 * e2 * e2 < d2) begin
        y += sty;
      end else begin
        x += stx;
        y += sty;
      end
      steps++;
      if (!cell_open(x, y)) halted = 1'b1;
    end
    res.visible = (x == bx && y == by);
    res.stop_x = x[4:0];
    res.stop_y = y[4:0];
    return res;
  endfunction

  function void note_input(sight_req_t r);
    if (r.kind == KIND_WRITE) begin
      wall_map[int'(r.start_y) * 32 + int'(r.start_x)] = r.blocks_sight;
    end else begin
      expected_sight.push_back(trace_sight(r));
    end
  endfunction

  function void flag(string msg);
    errors++;
    if (errors <= 10) $display("tb: %s", msg);
  endfunction

  function void check_result(logic [OUT_DW-1:0] d);
    sight_res_t got, want;
    got.visible      = d[0];
    got.stop_x       = d[5:1];
    got.stop_y       = d[10:6];
    got.out_of_range = d[11];
    if (expected_sight.size() == 0) begin
      flag($sformatf("result with none expected: vis %0d stop (%0d,%0d) oor %0d",
                     got.visible, got.stop_x, got.stop_y, got.out_of_range));
      return;
    end
    want = expected_sight.pop_front();
    if (got.visible !== want.visible || got.stop_x !== want.stop_x ||
        got.stop_y !== want.stop_y || got.out_of_range !== want.out_of_range) begin
      flag($sformatf({"mismatch: expected vis %0d stop (%0d,%0d) oor %0d, ",
                      "got vis %0d stop (%0d,%0d) oor %0d"},
                     want.visible, want.stop_x, want.stop_y, want.out_of_range,
                     got.visible, got.stop_x, got.stop_y, got.out_of_range));
    end
  endfunction
endclass

module tb;

  localparam int IDLE_WAIT  = 2 * MAP_SIZE_DEF + 16;
  localparam int STALL_LIMIT = 4000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // Fields from bit 0: start_x[5], start_y[5], end_x[5], end_y[5],
  // max_range[6], blocks_sight[1], zero fill.
  logic [IN_DW-1:0]    s_axis_tdata = '0;
  // Fields from bit 0: kind[1].
  logic                s_axis_tuser = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // Fields from bit 0: visible[1], stop_x[5], stop_y[5], out_of_range[1],
  // zero fill.
  logic [OUT_DW-1:0]   m_axis_tdata;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [APB_AW-1:0]   paddr = '0;
  logic [APB_DW-1:0]   pwdata = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  sight_scoreboard sb;
  int burst_left = 0;
  int rx_left = 0;
  int rx_mode = 0;
  int quiet_cycles = 0;
  int phase_w [8] = '{32, 1, 32, 0, 63, 17, 63, 0};
  int phase_h [8] = '{32, 32, 1, 63, 0, 9, 45, 0};

  grid_line_of_sight_walker DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic sight_req_t mk_req(logic kind, int sx, int sy, int ex, int ey,
                                        int rng, logic blk);
    sight_req_t r;
    r.kind = kind;
    r.start_x = sx[4:0];
    r.start_y = sy[4:0];
    r.end_x = ex[4:0];
    r.end_y = ey[4:0];
    r.max_range = rng[5:0];
    r.blocks_sight = blk;
    return r;
  endfunction

  task automatic send_req(input sight_req_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tdata  <= {5'b0, r.blocks_sight, r.max_range, r.end_y, r.end_x,
                      r.start_y, r.start_x};
    s_axis_tuser  <= r.kind;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_input(r);
  endtask

  task automatic cfg_write(input logic reg_sel, input int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(int'(reg_sel) * 4);
    pwdata  <= APB_DW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.set_reg(reg_sel, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_sight.size() != 0) @(posedge clk_i);
    repeat (IDLE_WAIT) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = (rx_mode == 2) ? $urandom_range(1, 24) : $urandom_range(4, 60);
    end
    rx_left--;
    case (rx_mode)
      0: begin
        m_axis_tready <= 1'b1;
      end
      1: begin
        m_axis_tready <= 1'($urandom_range(0, 1));
      end
      default: begin
        m_axis_tready <= 1'b0;
      end
    endcase
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    sight_req_t directed [$];
    sight_req_t r;
    int ph, n, count, wb, hb;
    sb = new;
    rst_ni <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed.push_back(mk_req(KIND_WRITE, 0, 0, 0, 0, 0, 1'b1));
    directed.push_back(mk_req(KIND_WRITE, 31, 31, 31, 31, 63, 1'b1));
    directed.push_back(mk_req(KIND_WRITE, 31, 31, 0, 0, 0, 1'b0));
    directed.push_back(mk_req(KIND_QUERY, 5, 5, 5, 5, 0, 1'b0));
    directed.push_back(mk_req(KIND_QUERY, 0, 0, 0, 0, 1, 1'b0));
    directed.push_back(mk_req(KIND_QUERY, 1, 1, 0, 0, 0, 1'b0));
    directed.push_back(mk_req(KIND_QUERY, 0, 0, 31, 21, 0, 1'b0));
    directed.push_back(mk_req(KIND_QUERY, 31, 21, 0, 0, 0, 1'b0));
    directed.push_back(mk_req(KIND_QUERY, 0, 0, 31, 31, 63, 1'b0));
    directed.push_back(mk_req(KIND_QUERY, 0, 0, 31, 31, 43, 1'b0));
    directed.push_back(mk_req(KIND_QUERY, 2, 2, 3, 2, 1, 1'b0));
    directed.push_back(mk_req(KIND_QUERY, 2, 2, 3, 3, 1, 1'b0));
    directed.push_back(mk_req(KIND_WRITE, 10, 5, 0, 0, 0, 1'b1));
    directed.push_back(mk_req(KIND_QUERY, 5, 5, 20, 5, 0, 1'b0));
    directed.push_back(mk_req(KIND_QUERY, 20, 5, 5, 5, 0, 1'b0));
    directed.push_back(mk_req(KIND_QUERY, 10, 0, 10, 10, 0, 1'b0));
    directed.push_back(mk_req(KIND_QUERY, 7, 2, 13, 8, 0, 1'b0));
    directed.push_back(mk_req(KIND_WRITE, 10, 5, 31, 31, 63, 1'b0));
    directed.push_back(mk_req(KIND_QUERY, 5, 5, 20, 5, 0, 1'b0));
    directed.push_back(mk_req(KIND_QUERY, 31, 0, 0, 21, 63, 1'b0));
    directed.push_back(mk_req(KIND_QUERY, 0, 31, 31, 0, 0, 1'b0));
    directed.push_back(mk_req(KIND_QUERY, 31, 31, 31, 31, 63, 1'b0));
    directed.push_back(mk_req(KIND_WRITE, 0, 0, 0, 0, 0, 1'b0));
    foreach (directed[i]) send_req(directed[i]);

    for (ph = 0; ph < 8; ph++) begin
      drain_results();
      if (ph == 7) begin
        phase_w[ph] = $urandom_range(1, 32);
        phase_h[ph] = $urandom_range(1, 32);
      end
      cfg_write(REG_MAP_WIDTH, phase_w[ph]);
      cfg_write(REG_MAP_HEIGHT, phase_h[ph]);
      wb = (phase_w[ph] > 32) ? 32 : phase_w[ph];
      hb = (phase_h[ph] > 32) ? 32 : phase_h[ph];
      count = (wb <= 1 || hb <= 1) ? 40 : 130;
      for (n = 0; n < count; n++) begin
        r.kind = ($urandom_range(0, 9) < 3) ? KIND_WRITE : KIND_QUERY;
        r.start_x = (wb > 0 && $urandom_range(0, 4) != 0) ? 5'($urandom_range(0, wb - 1))
                                                          : 5'($urandom_range(0, 31));
        r.start_y = (hb > 0 && $urandom_range(0, 4) != 0) ? 5'($urandom_range(0, hb - 1))
                                                          : 5'($urandom_range(0, 31));
        r.end_x = (wb > 0 && $urandom_range(0, 4) != 0) ? 5'($urandom_range(0, wb - 1))
                                                        : 5'($urandom_range(0, 31));
        r.end_y = (hb > 0 && $urandom_range(0, 4) != 0) ? 5'($urandom_range(0, hb - 1))
                                                        : 5'($urandom_range(0, 31));
        r.max_range = ($urandom_range(0, 1) == 0) ? 6'd0 : 6'($urandom_range(1, 63));
        r.blocks_sight = ($urandom_range(0, 9) < 3);
        send_req(r);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (sb.expected_sight.size() != 0) @(posedge clk_i);
    repeat (IDLE_WAIT) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_sight.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/glsw_pkg.sv
rtl/core/glsw_ram.sv
rtl/core/glsw_ctrl.sv
rtl/core/glsw_dp.sv
rtl/core/grid_line_of_sight_walker.sv
bench/tb.sv
